// File: design/trde_pkg.sv
// Shared types and constants for the touch release debounce block.
// No dependencies; used by trde_ctrl, trde_datapath and the top level.
package trde_pkg;

    localparam int NUM_ELECTRODES = 12;
    localparam int ELEC_W         = 4;
    localparam int THR_W          = 8;
    localparam int TIME_W         = 32;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;

    localparam logic [ELEC_W-1:0] LAST_ELEC = ELEC_W'(NUM_ELECTRODES - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME_US    = 1'd1;

    localparam logic [THR_W-1:0]  RESET_THRESHOLD = 8'd4;
    localparam logic [TIME_W-1:0] RESET_SETTLE_US = 32'd500000;

    // controller -> datapath
    typedef struct packed {
        logic load;       // take a new scan
        logic step;       // filter the current electrode and advance
        logic record;     // with step: latch event into the pending slot
        logic push;       // move pending event to output, not last
        logic push_last;  // move pending event to output as last of scan
    } trde_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic diff;       // filtered state differs from reported state
        logic settle;     // scan falls inside the settle period
        logic pend_valid; // an event waits in the pending slot
        logic last_idx;   // current electrode is the final one
        logic out_free;   // output register can take an item this cycle
    } trde_sts_t;

endpackage

// File: design/trde_ctrl.sv
// Scan sequencer for the touch release debounce block.
// Depends on trde_pkg for command and status types.
module trde_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  trde_pkg::trde_sts_t sts,
    output trde_pkg::trde_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!sts.diff)
                begin
                    cmd.step = 1'b1;
                    if (sts.last_idx)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
                else if (sts.settle)
                begin
                    // first change in settle period ends the scan silently
                    cmd.step   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.step   = 1'b1;
                    cmd.record = 1'b1;
                    cmd.push   = sts.pend_valid;
                    if (sts.last_idx)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!sts.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.push_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_step_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(cmd.step || cmd.push || cmd.push_last))
        else $error("step or push issued while idle");

    a_last_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_last |-> sts.pend_valid)
        else $error("last item pushed with no pending event");

    a_settle_never_records: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.record |-> !sts.settle)
        else $error("event recorded during settle period");

endmodule

// File: design/trde_datapath.sv
// Filter state, pending event slot and output register for the touch
// release debounce block. Depends on trde_pkg.
module trde_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  trde_pkg::trde_cmd_t                 cmd,
    output trde_pkg::trde_sts_t                 sts,
    input  logic [trde_pkg::NUM_ELECTRODES-1:0] in_bits,
    input  logic [trde_pkg::TIME_W-1:0]         in_time_us,
    input  logic                                cfg_we,
    input  logic [trde_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [trde_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [trde_pkg::ELEC_W-1:0]         out_electrode,
    output logic                                out_pressed,
    output logic                                out_last
);

    logic [trde_pkg::THR_W-1:0]          thr_reg;
    logic [trde_pkg::TIME_W-1:0]         settle_us_reg;

    logic [trde_pkg::NUM_ELECTRODES-1:0] bits_reg;
    logic                                settle_reg;
    logic [trde_pkg::ELEC_W-1:0]         idx_reg;

    logic [trde_pkg::NUM_ELECTRODES-1:0] filt_reg;
    logic [trde_pkg::NUM_ELECTRODES-1:0] rep_reg;
    logic [trde_pkg::THR_W-1:0]          cnt_reg [trde_pkg::NUM_ELECTRODES];

    logic                                pend_valid_reg;
    logic [trde_pkg::ELEC_W-1:0]         pend_elec_reg;
    logic                                pend_pressed_reg;

    logic                                out_valid_reg;
    logic [trde_pkg::ELEC_W-1:0]         out_elec_reg;
    logic                                out_pressed_reg;
    logic                                out_last_reg;

    logic                                raw;
    logic [trde_pkg::THR_W-1:0]          cnt_inc;
    logic                                filt_next;
    logic [trde_pkg::THR_W-1:0]          cnt_next;

    // per-electrode filter update
    always_comb
    begin
        raw     = bits_reg[idx_reg];
        cnt_inc = cnt_reg[idx_reg] + 1'b1;
        if (raw)
        begin
            filt_next = 1'b1;
            cnt_next  = '0;
        end
        else if (filt_reg[idx_reg])
        begin
            if (cnt_inc >= thr_reg)
            begin
                filt_next = 1'b0;
                cnt_next  = '0;
            end
            else
            begin
                filt_next = 1'b1;
                cnt_next  = cnt_inc;
            end
        end
        else
        begin
            filt_next = 1'b0;
            cnt_next  = cnt_reg[idx_reg];
        end
    end

    always_comb
    begin
        sts.diff       = filt_next != rep_reg[idx_reg];
        sts.settle     = settle_reg;
        sts.pend_valid = pend_valid_reg;
        sts.last_idx   = idx_reg == trde_pkg::LAST_ELEC;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= trde_pkg::RESET_THRESHOLD;
            settle_us_reg <= trde_pkg::RESET_SETTLE_US;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                trde_pkg::REG_RELEASE_THRESHOLD: thr_reg <= cfg_wdata[trde_pkg::THR_W-1:0];
                trde_pkg::REG_SETTLE_TIME_US:    settle_us_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // scan context; payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bits_reg   <= in_bits;
            settle_reg <= in_time_us < settle_us_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            filt_reg <= '0;
            rep_reg  <= '0;
            for (int i = 0; i < trde_pkg::NUM_ELECTRODES; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg           <= idx_reg + 1'b1;
                filt_reg[idx_reg] <= filt_next;
                cnt_reg[idx_reg]  <= cnt_next;
                if (cmd.record)
                begin
                    rep_reg[idx_reg] <= filt_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.step && cmd.record)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (cmd.push_last)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && cmd.record)
        begin
            pend_elec_reg    <= idx_reg;
            pend_pressed_reg <= filt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push || cmd.push_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.push_last)
        begin
            out_elec_reg    <= pend_elec_reg;
            out_pressed_reg <= pend_pressed_reg;
            out_last_reg    <= cmd.push_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_electrode = out_elec_reg;
    assign out_pressed   = out_pressed_reg;
    assign out_last      = out_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push || cmd.push_last) |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while stalled");

    a_pending_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && cmd.record && pend_valid_reg) |-> cmd.push)
        else $error("pending event replaced without being pushed");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (idx_reg <= trde_pkg::LAST_ELEC))
        else $error("electrode index out of range");

endmodule

// File: design/touch_release_debounce_events.sv
// Top level of the touch release debounce block: scan controller plus
// datapath. Depends on trde_pkg, trde_ctrl and trde_datapath.
//
//  channel  | dir | handshake          | contents
//  ---------+-----+--------------------+---------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | one scan: raw touch bits and time
//  m_*      | out | m_tvalid/m_tready  | one on/off event, m_tlast ends a scan
//  cfg_*    | in  | cfg_we             | release threshold, settle time
//
// An item is accepted in ST_IDLE, then the electrodes are visited one per
// cycle unless a new event waits on a stalled output, then ST_FLUSH pushes any
// final event; the single shared filter unit takes no new item before that.
// Events leave through a pending slot and an output register, so the last
// event of a scan is marked once the scan is known to have no more.
// A stalled m_tready holds the scan on an electrode with a new event if one is pending.
// Reset clears all filter, count and reported state; threshold 4, settle 500 ms.
// s_tready is high only between scans; it stays low while a final event waits to flush.
module touch_release_debounce_events (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,   // [11:0] touch_bits, [43:12] time_us
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [3:0] electrode, [4] pressed
    output logic                                m_tlast,   // last event of the scan
    input  logic                                cfg_we,
    input  logic [trde_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [trde_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    trde_pkg::trde_cmd_t         cmd;
    trde_pkg::trde_sts_t         sts;
    logic [trde_pkg::ELEC_W-1:0] electrode;
    logic                        pressed;

    trde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    trde_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_bits       (s_tdata[11:0]),
        .in_time_us    (s_tdata[43:12]),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_electrode (electrode),
        .out_pressed   (pressed),
        .out_last      (m_tlast)
    );

    // electrode in the low nibble, pressed above it, zero fill to the byte
    assign m_tdata = {3'b000, pressed, electrode};

endmodule
